>>> rtl/brs_pkg.sv
package brs_pkg;

  localparam int unsigned CFG_W          = 10;
  localparam int unsigned TGT_W          = 9;
  localparam int unsigned PIX_W          = 8;
  localparam int unsigned RGB_W          = 3 * PIX_W;
  localparam int unsigned FRAC_W         = 16;
  localparam int unsigned STEP_W         = 26;
  localparam int unsigned PROD_W         = CFG_W + STEP_W;
  localparam int unsigned WGT_W          = 17;
  localparam int unsigned ACC_W          = 24;
  localparam int unsigned MAX_WIDTH_DEF  = 512;
  localparam int unsigned MAX_HEIGHT_DEF = 512;

  localparam logic [STEP_W-1:0] STEP_ONE   = STEP_W'(1 << FRAC_W);
  localparam logic [PROD_W-1:0] HALF_TWICE = PROD_W'(1 << FRAC_W);
  localparam logic [ACC_W-1:0]  ROUND_HALF = ACC_W'(1 << (FRAC_W - 1));

  typedef enum logic [1:0] {
    REG_SRC_W,
    REG_SRC_H,
    REG_DST_W,
    REG_DST_H
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD,
    OP_FETCH
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TOT,
    ST_DXS,
    ST_DXW,
    ST_DYS,
    ST_DYW,
    ST_MAPX,
    ST_MAPY,
    ST_YDEC,
    ST_ROW0,
    ST_ROW1,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_ACC,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [CFG_W-1:0] i0;
    logic [CFG_W-1:0] i1;
    logic [PIX_W-1:0] f;
  } coord_t;

  function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v,
                                                input int unsigned     maxv);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (32'(v) > maxv) begin
      r = CFG_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // twice holds (2t+1)*step, size is the clamped source dimension
  function automatic coord_t map_coord(input logic [PROD_W-1:0] twice,
                                       input logic [CFG_W-1:0]  size);
    logic [PROD_W-1:0]        diff;
    logic [PROD_W-2:0]        s;
    logic [PROD_W-2-FRAC_W:0] ip;
    coord_t                   c;
    diff = twice - HALF_TWICE;
    s    = (twice < HALF_TWICE) ? '0 : diff[PROD_W-1:1];
    ip   = s[PROD_W-2:FRAC_W];
    if (ip >= (PROD_W-1-FRAC_W)'(size)) begin
      c.i0 = size - 1'b1;
      c.f  = '0;
    end else begin
      c.i0 = ip[CFG_W-1:0];
      c.f  = s[FRAC_W-1:FRAC_W-PIX_W];
    end
    c.i1 = (({1'b0, c.i0} + 1'b1) < {1'b0, size}) ? c.i0 + 1'b1 : size - 1'b1;
    return c;
  endfunction

endpackage

>>> rtl/brs_div.sv
module brs_div #(
  parameter int unsigned DVD_W = brs_pkg::STEP_W,
  parameter int unsigned DVS_W = brs_pkg::CFG_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DVD_W + 1);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, quo_q[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign ge      = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      cnt_d = CntW'(DVD_W);
      run_d = 1'b1;
      rem_d = '0;
      quo_d = dividend_i;
    end else if (run_q) begin
      rem_d = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> rtl/bilinear_rgb_scaler.sv
// Bilinear RGB scaler with half-pixel-centre sampling. A load beat writes
// the next source pixel in raster order into a single-port frame memory of
// MAX_WIDTH*MAX_HEIGHT words. For a fetch beat, one shared 10x26 multiplier
// maps x and y, forms the two row addresses and the four blend weights, and
// the frame memory returns one neighbour per cycle, before the result enters
// the output register; an out-of-range fetch skips these steps. A finished
// result waits in the output register while the next beat is taken. Each
// configuration write starts a serial divider that recomputes both scale
// ratios one quotient bit per cycle; input stays stalled after the last write
// until both ratios are recomputed.
module bilinear_rgb_scaler #(
  parameter int unsigned MAX_WIDTH  = brs_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = brs_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [brs_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        operation_i,
  input  logic [brs_pkg::PIX_W-1:0]   in_red_i,
  input  logic [brs_pkg::PIX_W-1:0]   in_green_i,
  input  logic [brs_pkg::PIX_W-1:0]   in_blue_i,
  input  logic [brs_pkg::TGT_W-1:0]   target_x_i,
  input  logic [brs_pkg::TGT_W-1:0]   target_y_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [brs_pkg::PIX_W-1:0]   out_red_o,
  output logic [brs_pkg::PIX_W-1:0]   out_green_o,
  output logic [brs_pkg::PIX_W-1:0]   out_blue_o,
  output logic                        out_of_range_o
);

  localparam int unsigned MemDepth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW    = $clog2(MemDepth);
  localparam int unsigned CfgW     = brs_pkg::CFG_W;
  localparam int unsigned PixW     = brs_pkg::PIX_W;
  localparam int unsigned StepW    = brs_pkg::STEP_W;
  localparam int unsigned ProdW    = brs_pkg::PROD_W;
  localparam int unsigned AccW     = brs_pkg::ACC_W;
  localparam int unsigned WgtW     = brs_pkg::WGT_W;
  localparam int unsigned RgbW     = brs_pkg::RGB_W;

  brs_pkg::state_e state_q, state_d;

  logic [CfgW-1:0]  sw_q, sh_q, dw_q, dh_q;
  logic [StepW-1:0] step_x_q, step_y_q;
  logic [AddrW:0]   total_q;
  logic [AddrW-1:0] wp_q, wp_d, wp_cur;
  logic [AddrW:0]   wp_inc;

  logic [brs_pkg::TGT_W-1:0] tx_q, ty_q;
  brs_pkg::coord_t  cx_q, cy_q;
  logic [AddrW-1:0] row0_q, row1_q;
  logic [ProdW-1:0] prod_q;
  logic [AccW-1:0]  acc_q [3];
  logic             oor_q;

  logic [RgbW-1:0]  mem [MemDepth];
  logic [RgbW-1:0]  rd_q;
  logic             mem_we;
  logic [AddrW-1:0] mem_addr;

  logic [CfgW-1:0]  mul_a;
  logic [StepW-1:0] mul_b;
  logic [ProdW-1:0] mul_p;

  logic             div_start;
  logic [StepW-1:0] div_dvd;
  logic [CfgW-1:0]  div_dvs;
  logic             div_done;
  logic [StepW-1:0] div_quo;

  logic             in_acc;
  logic             is_fetch;
  logic             fetch_oor;
  logic             out_load;
  logic [PixW:0]    wx0, wy0;
  logic [WgtW-1:0]  wgt;
  logic [WgtW+PixW-1:0] lane_prod [3];

  logic                out_valid_q;
  logic [PixW-1:0]     out_red_q, out_green_q, out_blue_q;
  logic                out_oor_q;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign is_fetch  = operation_i == brs_pkg::OP_FETCH;
  assign fetch_oor = ({1'b0, target_x_i} >= dw_q) || ({1'b0, target_y_i} >= dh_q);
  assign out_load  = (state_q == brs_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);

  assign wx0 = (PixW+1)'(1 << PixW) - {1'b0, cx_q.f};
  assign wy0 = (PixW+1)'(1 << PixW) - {1'b0, cy_q.f};
  assign wgt = prod_q[WgtW-1:0];

  assign wp_cur = ({1'b0, wp_q} >= total_q) ? '0 : wp_q;
  assign wp_inc = {1'b0, wp_cur} + 1'b1;
  assign wp_d   = (wp_inc >= total_q) ? '0 : wp_inc[AddrW-1:0];

  assign mul_p = {{StepW{1'b0}}, mul_a} * {{CfgW{1'b0}}, mul_b};

  brs_div #(
    .DVD_W(StepW),
    .DVS_W(CfgW)
  ) u_brs_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dvs),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      brs_pkg::ST_IDLE: begin
        if (in_acc && is_fetch) begin
          state_d = fetch_oor ? brs_pkg::ST_DONE : brs_pkg::ST_MAPX;
        end
      end
      brs_pkg::ST_TOT:  state_d = brs_pkg::ST_DXS;
      brs_pkg::ST_DXS:  state_d = brs_pkg::ST_DXW;
      brs_pkg::ST_DXW: begin
        if (div_done) begin
          state_d = brs_pkg::ST_DYS;
        end
      end
      brs_pkg::ST_DYS:  state_d = brs_pkg::ST_DYW;
      brs_pkg::ST_DYW: begin
        if (div_done) begin
          state_d = brs_pkg::ST_IDLE;
        end
      end
      brs_pkg::ST_MAPX: state_d = brs_pkg::ST_MAPY;
      brs_pkg::ST_MAPY: state_d = brs_pkg::ST_YDEC;
      brs_pkg::ST_YDEC: state_d = brs_pkg::ST_ROW0;
      brs_pkg::ST_ROW0: state_d = brs_pkg::ST_ROW1;
      brs_pkg::ST_ROW1: state_d = brs_pkg::ST_RD0;
      brs_pkg::ST_RD0:  state_d = brs_pkg::ST_RD1;
      brs_pkg::ST_RD1:  state_d = brs_pkg::ST_RD2;
      brs_pkg::ST_RD2:  state_d = brs_pkg::ST_RD3;
      brs_pkg::ST_RD3:  state_d = brs_pkg::ST_ACC;
      brs_pkg::ST_ACC:  state_d = brs_pkg::ST_DONE;
      brs_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = brs_pkg::ST_IDLE;
        end
      end
      default: state_d = brs_pkg::ST_IDLE;
    endcase
    if (cfg_we_i) begin
      state_d = brs_pkg::ST_TOT;
    end
  end

  // control outputs and operand selection
  always_comb begin
    in_stall_o = state_q != brs_pkg::ST_IDLE;
    mem_we     = 1'b0;
    mem_addr   = wp_cur;
    mul_a      = sw_q;
    mul_b      = {{(StepW-CfgW){1'b0}}, sh_q};
    div_start  = 1'b0;
    div_dvd    = {sw_q, {brs_pkg::FRAC_W{1'b0}}};
    div_dvs    = dw_q;
    case (state_q)
      brs_pkg::ST_IDLE: begin
        mem_we = in_acc && !is_fetch;
      end
      brs_pkg::ST_DXS: begin
        div_start = 1'b1;
      end
      brs_pkg::ST_DYS: begin
        div_start = 1'b1;
        div_dvd   = {sh_q, {brs_pkg::FRAC_W{1'b0}}};
        div_dvs   = dh_q;
      end
      brs_pkg::ST_MAPX: begin
        mul_a = {tx_q, 1'b1};
        mul_b = step_x_q;
      end
      brs_pkg::ST_MAPY: begin
        mul_a = {ty_q, 1'b1};
        mul_b = step_y_q;
      end
      brs_pkg::ST_ROW0: begin
        mul_a = cy_q.i0;
        mul_b = {{(StepW-CfgW){1'b0}}, sw_q};
      end
      brs_pkg::ST_ROW1: begin
        mul_a = cy_q.i1;
        mul_b = {{(StepW-CfgW){1'b0}}, sw_q};
      end
      brs_pkg::ST_RD0: begin
        mem_addr = row0_q + AddrW'(cx_q.i0);
        mul_a    = {1'b0, wx0};
        mul_b    = {{(StepW-PixW-1){1'b0}}, wy0};
      end
      brs_pkg::ST_RD1: begin
        mem_addr = row0_q + AddrW'(cx_q.i1);
        mul_a    = {2'b0, cx_q.f};
        mul_b    = {{(StepW-PixW-1){1'b0}}, wy0};
      end
      brs_pkg::ST_RD2: begin
        mem_addr = row1_q + AddrW'(cx_q.i0);
        mul_a    = {1'b0, wx0};
        mul_b    = {{(StepW-PixW){1'b0}}, cy_q.f};
      end
      brs_pkg::ST_RD3: begin
        mem_addr = row1_q + AddrW'(cx_q.i1);
        mul_a    = {2'b0, cx_q.f};
        mul_b    = {{(StepW-PixW){1'b0}}, cy_q.f};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lane_prod[c] = (WgtW+PixW)'(rd_q[RgbW-1-PixW*c -: PixW]) * (WgtW+PixW)'(wgt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= brs_pkg::ST_IDLE;
      sw_q        <= CfgW'(1);
      sh_q        <= CfgW'(1);
      dw_q        <= CfgW'(1);
      dh_q        <= CfgW'(1);
      step_x_q    <= brs_pkg::STEP_ONE;
      step_y_q    <= brs_pkg::STEP_ONE;
      total_q     <= (AddrW+1)'(1);
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (brs_pkg::cfg_reg_e'(cfg_idx_i))
          brs_pkg::REG_SRC_W: sw_q <= brs_pkg::eff_size(cfg_data_i, MAX_WIDTH);
          brs_pkg::REG_SRC_H: sh_q <= brs_pkg::eff_size(cfg_data_i, MAX_HEIGHT);
          brs_pkg::REG_DST_W: dw_q <= brs_pkg::eff_size(cfg_data_i, MAX_WIDTH);
          brs_pkg::REG_DST_H: dh_q <= brs_pkg::eff_size(cfg_data_i, MAX_HEIGHT);
          default:            sw_q <= sw_q;
        endcase
      end
      if (state_q == brs_pkg::ST_DXS) begin
        total_q <= prod_q[AddrW:0];
      end
      if (state_q == brs_pkg::ST_DXW && div_done) begin
        step_x_q <= div_quo;
      end
      if (state_q == brs_pkg::ST_DYW && div_done) begin
        step_y_q <= div_quo;
      end
      if (mem_we) begin
        wp_q <= wp_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (state_q == brs_pkg::ST_IDLE && in_acc && is_fetch) begin
      tx_q  <= target_x_i;
      ty_q  <= target_y_i;
      oor_q <= fetch_oor;
      for (int c = 0; c < 3; c++) begin
        acc_q[c] <= '0;
      end
    end
    if (state_q == brs_pkg::ST_MAPY) begin
      cx_q <= brs_pkg::map_coord(prod_q, sw_q);
    end
    if (state_q == brs_pkg::ST_YDEC) begin
      cy_q <= brs_pkg::map_coord(prod_q, sh_q);
    end
    if (state_q == brs_pkg::ST_ROW1) begin
      row0_q <= prod_q[AddrW-1:0];
    end
    if (state_q == brs_pkg::ST_RD0) begin
      row1_q <= prod_q[AddrW-1:0];
      for (int c = 0; c < 3; c++) begin
        acc_q[c] <= brs_pkg::ROUND_HALF;
      end
    end
    if (state_q == brs_pkg::ST_RD1 || state_q == brs_pkg::ST_RD2 ||
        state_q == brs_pkg::ST_RD3 || state_q == brs_pkg::ST_ACC) begin
      for (int c = 0; c < 3; c++) begin
        acc_q[c] <= acc_q[c] + lane_prod[c][AccW-1:0];
      end
    end
    if (out_load) begin
      out_red_q   <= acc_q[0][AccW-1 -: PixW];
      out_green_q <= acc_q[1][AccW-1 -: PixW];
      out_blue_q  <= acc_q[2][AccW-1 -: PixW];
      out_oor_q   <= oor_q;
    end
  end

  // frame memory, single port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= {in_red_i, in_green_i, in_blue_i};
    end
    rd_q <= mem[mem_addr];
  end

  assign out_valid_o    = out_valid_q;
  assign out_red_o      = out_red_q;
  assign out_green_o    = out_green_q;
  assign out_blue_o     = out_blue_q;
  assign out_of_range_o = out_oor_q;

endmodule

>>> rtl/brs_checker.sv
module brs_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      operation_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [brs_pkg::PIX_W-1:0] out_red_o,
  input logic [brs_pkg::PIX_W-1:0] out_green_o,
  input logic [brs_pkg::PIX_W-1:0] out_blue_o,
  input logic                      out_of_range_o
);

  logic in_beat;
  assign in_beat = in_valid_i && !in_stall_o;

  // out-of-range results carry black
  a_oor_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |->
      out_red_o == '0 && out_green_o == '0 && out_blue_o == '0)
    else $error("out-of-range result with nonzero colour");

  // a fetch keeps the input stalled while it is worked on
  a_fetch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && operation_i == brs_pkg::OP_FETCH |=> in_stall_o)
    else $error("input taken during a fetch");

  // a load never produces a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && operation_i == brs_pkg::OP_LOAD && !out_valid_o |=> !out_valid_o)
    else $error("result after a load beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_red_o) &&
      $stable(out_green_o) && $stable(out_blue_o) && $stable(out_of_range_o))
    else $error("stalled output beat changed");

endmodule

bind bilinear_rgb_scaler brs_checker u_brs_checker (.*);
